// File: hdl/svm_pkg.sv
// Shared types and constants of the stack machine executor.
// Opcodes, fault codes, field widths and the stack cell control word.
// No dependencies.
package svm_pkg;

    localparam int BYTE_W     = 8;
    localparam int OP_W       = 4;
    localparam int FAULT_W    = 2;
    localparam int DEPTH_W    = 9;
    localparam int DATA_BYTES = 256;
    localparam int DATA_AW    = 8;

    typedef enum logic [OP_W-1:0] {
        OP_NOP    = 4'd0,
        OP_ADD    = 4'd1,
        OP_MULT   = 4'd2,
        OP_LIT    = 4'd3,
        OP_EMIT   = 4'd4,
        OP_POP    = 4'd5,
        OP_PUSH   = 4'd6,
        OP_STR    = 4'd7,
        OP_LOAD   = 4'd8,
        OP_STA    = 4'd9,
        OP_LDA    = 4'd10,
        OP_HALT   = 4'd11
    } t_op;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_UNDER = 2'd1,
        FAULT_OVER  = 2'd2,
        FAULT_REG   = 2'd3
    } t_fault;

    // Where a stack cell takes its next value from.
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_PREV = 2'd1,
        SH_NEXT = 2'd2
    } t_shift;

    typedef struct packed {
        t_shift             top_sel;
        t_shift             rest_sel;
        logic [BYTE_W-1:0]  top_val;
        logic               inc;
        logic               dec;
    } t_stk_ctl;

endpackage

// File: hdl/svm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module svm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/svm_cell.sv
// One stack cell: a byte that holds, or takes its upper or lower neighbor.
// Uses svm_pkg for the shift select type.
module svm_cell
    import svm_pkg::*;
(
    input  logic              i_clk,
    input  t_shift            i_sel,
    input  logic [BYTE_W-1:0] i_prev,
    input  logic [BYTE_W-1:0] i_next,
    output logic [BYTE_W-1:0] o_q
);

    logic [BYTE_W-1:0] r_q;
    logic [BYTE_W-1:0] n_q;

    always_comb begin
        case (i_sel)
            SH_PREV: n_q = i_prev;
            SH_NEXT: n_q = i_next;
            default: n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

// File: hdl/svm_stack.sv
// Byte stack as a chain of svm_cell, top of stack in cell 0, plus fill count.
// Uses svm_pkg and svm_cell.
module svm_stack
    import svm_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stk_ctl          i_ctl,
    output logic [BYTE_W-1:0] o_top,
    output logic [BYTE_W-1:0] o_second,
    output logic [CW-1:0]     o_count
);

    logic [BYTE_W-1:0] w_q [STACK_DEPTH];
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [BYTE_W-1:0] w_prev;
            logic [BYTE_W-1:0] w_next;
            t_shift            w_sel;
            if (gi == 0) begin : g_top
                assign w_prev = i_ctl.top_val;
                assign w_sel  = i_ctl.top_sel;
            end else begin : g_body
                assign w_prev = w_q[gi-1];
                assign w_sel  = i_ctl.rest_sel;
            end
            if (gi == STACK_DEPTH - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_q[gi+1];
            end
            svm_cell u_cell (
                .i_clk  (i_clk),
                .i_sel  (w_sel),
                .i_prev (w_prev),
                .i_next (w_next),
                .o_q    (w_q[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (i_ctl.inc) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.dec) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top    = w_q[0];
    assign o_second = w_q[1];
    assign o_count  = r_count;

endmodule

// File: hdl/stack_vm_instruction_executor.sv
// Top level of the 8-bit stack machine executor: fetch stage, execute stage,
// output register. Uses svm_pkg, svm_stack and svm_ram.
//
// Executes one instruction per input item and returns one result item for
// each. The block is a two-stage pipeline and sustains one item per clock
// while results are taken: the fetch stage reads the register file and issues
// the data store read; in the execute stage the stack, held in a row of byte
// cells with the top of stack in the first cell, shifts by one place and the
// result is registered. Stack contents move as a shift line, so add and multiply
// read both operands at once. Register and data store writes are forwarded to
// the following item. Items pass the execute stage registers, then the output
// register. A full output register that is not taken stalls the execute stage
// and drops input ready. There is no clearing pass after reset.
module stack_vm_instruction_executor
    import svm_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int NUM_REGS    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [3:0] op, [11:4] operand, [15:12] zero
    input  logic [15:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] print_valid, [8:1] print_value, [9] halted, [11:10] fault,
    // [20:12] depth, [23:21] zero
    output logic [23:0] o_m_tdata
);

    localparam int CW     = $clog2(STACK_DEPTH + 1);
    localparam int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // ---------------- fetch stage ----------------
    logic                w_accept;
    logic [OP_W-1:0]     w_a_op;
    logic [BYTE_W-1:0]   w_a_arg;
    logic [RIDX_W-1:0]   w_a_ridx;
    logic [BYTE_W-1:0]   w_a_regv;
    logic [DATA_AW-1:0]  w_a_addr;

    logic [BYTE_W-1:0]   r_regs [NUM_REGS];
    logic [DATA_BYTES-1:0] r_dvalid;

    // execute stage registers
    logic                r_b_valid;
    logic [OP_W-1:0]     r_b_op;
    logic [BYTE_W-1:0]   r_b_arg;
    logic [BYTE_W-1:0]   r_b_regv;
    logic [DATA_AW-1:0]  r_b_addr;
    logic                r_b_fwd_hit;
    logic [BYTE_W-1:0]   r_b_fwd_val;
    logic                r_b_dvalid;

    // execute stage signals
    logic                w_b_fire;
    logic                w_reg_we;
    logic                w_dat_we;
    logic [BYTE_W-1:0]   w_top;
    logic [BYTE_W-1:0]   w_second;
    logic [CW-1:0]       w_count;
    logic [BYTE_W-1:0]   w_ram_q;
    logic [BYTE_W-1:0]   w_b_dat;
    t_stk_ctl            w_ctl;
    t_fault              w_fault;
    logic                w_pv;
    logic [BYTE_W-1:0]   w_pval;
    logic                w_halt_now;
    logic                r_stop;

    // output register
    logic                r_o_valid;
    logic                r_o_pv;
    logic [BYTE_W-1:0]   r_o_pval;
    logic                r_o_halted;
    t_fault              r_o_fault;
    logic [DEPTH_W-1:0]  r_o_depth;

    assign w_b_fire   = r_b_valid && (!r_o_valid || i_m_tready);
    assign o_s_tready = !r_b_valid || w_b_fire;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_a_op   = i_s_tdata[3:0];
    assign w_a_arg  = i_s_tdata[11:4];
    assign w_a_ridx = w_a_arg[RIDX_W-1:0];

    // Bypass a register write from the item now leaving execute.
    always_comb begin
        if (w_reg_we && (r_b_arg[RIDX_W-1:0] == w_a_ridx)) begin
            w_a_regv = w_top;
        end else begin
            w_a_regv = r_regs[w_a_ridx];
        end
        if (w_a_op == OP_STR || w_a_op == OP_LOAD) begin
            w_a_addr = w_a_regv[DATA_AW-1:0];
        end else begin
            w_a_addr = w_a_arg[DATA_AW-1:0];
        end
    end

    svm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_BYTES)
    ) u_data (
        .i_clk   (i_clk),
        .i_we    (w_dat_we),
        .i_waddr (r_b_addr),
        .i_wdata (w_top),
        .i_re    (w_accept),
        .i_raddr (w_a_addr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_accept) begin
            r_b_valid <= 1'b1;
        end else if (w_b_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_op      <= w_a_op;
            r_b_arg     <= w_a_arg;
            r_b_regv    <= w_a_regv;
            r_b_addr    <= w_a_addr;
            r_b_fwd_hit <= w_dat_we && (r_b_addr == w_a_addr);
            r_b_fwd_val <= w_top;
            r_b_dvalid  <= r_dvalid[w_a_addr];
        end
    end

    // ---------------- execute stage ----------------
    assign w_b_dat = r_b_fwd_hit ? r_b_fwd_val : (r_b_dvalid ? w_ram_q : '0);

    svm_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .CW          (CW)
    ) u_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .o_top    (w_top),
        .o_second (w_second),
        .o_count  (w_count)
    );

    always_comb begin
        logic              reg_op;
        logic              bad_reg;
        logic              do_push;
        logic              do_pop;
        logic              do_alu;
        logic [2*BYTE_W-1:0] prod;
        logic [BYTE_W-1:0] alu_r;
        logic [BYTE_W-1:0] push_v;

        reg_op  = r_b_op inside {OP_POP, OP_PUSH, OP_STR, OP_LOAD};
        bad_reg = {1'b0, r_b_arg} >= 9'(NUM_REGS);
        prod    = {{BYTE_W{1'b0}}, w_top} * {{BYTE_W{1'b0}}, w_second};
        w_fault    = FAULT_NONE;
        w_pv       = 1'b0;
        w_pval     = '0;
        w_halt_now = 1'b0;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        do_alu     = 1'b0;
        w_reg_we   = 1'b0;
        w_dat_we   = 1'b0;
        push_v     = w_b_dat;

        case (r_b_op)
            OP_LIT:   push_v = r_b_arg;
            OP_PUSH:  push_v = r_b_regv;
            default:  push_v = w_b_dat;
        endcase
        if (r_b_op == OP_ADD) begin
            alu_r = w_top + w_second;
        end else begin
            alu_r = prod[BYTE_W-1:0];
        end

        if (!r_stop) begin
            if (reg_op && bad_reg) begin
                w_fault = FAULT_REG;
            end else begin
                case (r_b_op)
                    OP_ADD, OP_MULT: begin
                        if (w_count < CW'(2)) begin
                            w_fault = FAULT_UNDER;
                        end else begin
                            do_alu = 1'b1;
                        end
                    end
                    OP_EMIT, OP_POP, OP_STR, OP_STA: begin
                        if (w_count == '0) begin
                            w_fault = FAULT_UNDER;
                        end else begin
                            do_pop   = 1'b1;
                            w_pv     = (r_b_op == OP_EMIT);
                            w_pval   = (r_b_op == OP_EMIT) ? w_top : '0;
                            w_reg_we = w_b_fire && (r_b_op == OP_POP);
                            w_dat_we = w_b_fire &&
                                       (r_b_op == OP_STR || r_b_op == OP_STA);
                        end
                    end
                    OP_LIT, OP_PUSH, OP_LOAD, OP_LDA: begin
                        if (w_count >= CW'(STACK_DEPTH)) begin
                            w_fault = FAULT_OVER;
                        end else begin
                            do_push = 1'b1;
                        end
                    end
                    OP_HALT: w_halt_now = 1'b1;
                    default: ;
                endcase
            end
        end

        w_ctl.top_sel  = SH_HOLD;
        w_ctl.rest_sel = SH_HOLD;
        w_ctl.top_val  = push_v;
        w_ctl.inc      = 1'b0;
        w_ctl.dec      = 1'b0;
        if (w_b_fire) begin
            if (do_push) begin
                w_ctl.top_sel  = SH_PREV;
                w_ctl.rest_sel = SH_PREV;
                w_ctl.inc      = 1'b1;
            end else if (do_pop) begin
                w_ctl.top_sel  = SH_NEXT;
                w_ctl.rest_sel = SH_NEXT;
                w_ctl.dec      = 1'b1;
            end else if (do_alu) begin
                // Replace the second byte by the result and close the gap.
                w_ctl.top_sel  = SH_PREV;
                w_ctl.rest_sel = SH_NEXT;
                w_ctl.top_val  = alu_r;
                w_ctl.dec      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop   <= 1'b0;
            r_dvalid <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (w_b_fire && w_halt_now) begin
                r_stop <= 1'b1;
            end
            if (w_dat_we) begin
                r_dvalid[r_b_addr] <= 1'b1;
            end
            if (w_reg_we) begin
                r_regs[r_b_arg[RIDX_W-1:0]] <= w_top;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_b_fire) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_fire) begin
            r_o_pv     <= w_pv;
            r_o_pval   <= w_pval;
            r_o_halted <= r_stop || w_halt_now;
            r_o_fault  <= w_fault;
            // Depth after this item: the count moves by at most one.
            if (w_ctl.inc) begin
                r_o_depth <= DEPTH_W'(w_count + CW'(1));
            end else if (w_ctl.dec) begin
                r_o_depth <= DEPTH_W'(w_count - CW'(1));
            end else begin
                r_o_depth <= DEPTH_W'(w_count);
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {3'b000, r_o_depth, r_o_fault, r_o_halted, r_o_pval, r_o_pv};

endmodule
